[hw/rtl/tioc_pkg.sv]
// tioc_pkg: shared types, codes and helpers of the tiled interval overlap counter
// used by tioc_ctrl, tioc_datapath and the top level; depends on nothing
package tioc_pkg;

   // transaction kinds
   localparam logic [1:0] KIND_BASE  = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_DROPPED = 2'd1;
   localparam logic [1:0] STATUS_BEYOND  = 2'd2;

   // tile size limits and derived chromosome-local tile width
   localparam logic [4:0] TB_MIN   = 5'd10;
   localparam logic [4:0] TB_MAX   = 5'd20;
   localparam logic [4:0] TB_RESET = 5'd14;
   localparam int         LOCAL_W  = 22;

   localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_BASE, S_LD_RD, S_LD_WR, S_Q_SETUP, S_TILE_RD,
      S_TILE_GO, S_REC_RD, S_REC_CMP, S_CNT_WR, S_RD_CNT, S_RD_OUT, S_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLEAR, OP_CAPTURE, OP_BASE, OP_LD_RD, OP_LD_WR, OP_Q_SETUP,
      OP_TILE_RD, OP_TILE_GO, OP_REC_RD, OP_NEXT_TILE, OP_FINISH, OP_HIT,
      OP_CNT_WR, OP_RD_CNT, OP_RD_OUT, OP_PUSH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic q_bad;
      logic rec_more;
      logic rec_hit;
      logic last_tile;
      logic out_free;
   } stat_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == SAT32) ? v : v + 32'd1;
   endfunction

endpackage

[hw/rtl/tioc_ctrl.sv]
// tioc_ctrl: sequencing state machine of the overlap counter
// depends on tioc_pkg; drives commands into tioc_datapath
module tioc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_kind,
   output logic               req_stall,
   input  tioc_pkg::stat_type stat,
   output tioc_pkg::cmd_type  cmd
);

   tioc_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tioc_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != tioc_pkg::S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd.op   = tioc_pkg::OP_NONE;
      case (state_ff)
         tioc_pkg::S_CLEAR: begin
            cmd.op = tioc_pkg::OP_CLEAR;
            if (stat.clear_done) state_in = tioc_pkg::S_IDLE;
         end
         tioc_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.op = tioc_pkg::OP_CAPTURE;
               case (req_kind)
                  tioc_pkg::KIND_BASE:  state_in = tioc_pkg::S_BASE;
                  tioc_pkg::KIND_LOAD:  state_in = tioc_pkg::S_LD_RD;
                  tioc_pkg::KIND_QUERY: state_in = tioc_pkg::S_Q_SETUP;
                  default:              state_in = tioc_pkg::S_RD_CNT;
               endcase
            end
         end
         tioc_pkg::S_BASE: begin
            cmd.op   = tioc_pkg::OP_BASE;
            state_in = tioc_pkg::S_DONE;
         end
         tioc_pkg::S_LD_RD: begin
            cmd.op   = tioc_pkg::OP_LD_RD;
            state_in = tioc_pkg::S_LD_WR;
         end
         tioc_pkg::S_LD_WR: begin
            cmd.op   = tioc_pkg::OP_LD_WR;
            state_in = tioc_pkg::S_DONE;
         end
         tioc_pkg::S_Q_SETUP: begin
            cmd.op   = tioc_pkg::OP_Q_SETUP;
            state_in = stat.q_bad ? tioc_pkg::S_DONE : tioc_pkg::S_TILE_RD;
         end
         tioc_pkg::S_TILE_RD: begin
            cmd.op   = tioc_pkg::OP_TILE_RD;
            state_in = tioc_pkg::S_TILE_GO;
         end
         tioc_pkg::S_TILE_GO: begin
            cmd.op   = tioc_pkg::OP_TILE_GO;
            state_in = tioc_pkg::S_REC_RD;
         end
         tioc_pkg::S_REC_RD: begin
            if (stat.rec_more) begin
               cmd.op   = tioc_pkg::OP_REC_RD;
               state_in = tioc_pkg::S_REC_CMP;
            end else if (stat.last_tile) begin
               cmd.op   = tioc_pkg::OP_FINISH;
               state_in = tioc_pkg::S_DONE;
            end else begin
               cmd.op   = tioc_pkg::OP_NEXT_TILE;
               state_in = tioc_pkg::S_TILE_RD;
            end
         end
         tioc_pkg::S_REC_CMP: begin
            if (stat.rec_hit) begin
               cmd.op   = tioc_pkg::OP_HIT;
               state_in = tioc_pkg::S_CNT_WR;
            end else begin
               state_in = tioc_pkg::S_REC_RD;
            end
         end
         tioc_pkg::S_CNT_WR: begin
            cmd.op   = tioc_pkg::OP_CNT_WR;
            state_in = tioc_pkg::S_REC_RD;
         end
         tioc_pkg::S_RD_CNT: begin
            cmd.op   = tioc_pkg::OP_RD_CNT;
            state_in = tioc_pkg::S_RD_OUT;
         end
         tioc_pkg::S_RD_OUT: begin
            cmd.op   = tioc_pkg::OP_RD_OUT;
            state_in = tioc_pkg::S_DONE;
         end
         tioc_pkg::S_DONE: begin
            if (stat.out_free) begin
               cmd.op   = tioc_pkg::OP_PUSH;
               state_in = tioc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tioc_pkg::S_CLEAR;
         end
      endcase
   end

endmodule

[hw/rtl/tioc_datapath.sv]
// tioc_datapath: tile tables, record stores, dataset counters and result register
// depends on tioc_pkg; commanded by tioc_ctrl
module tioc_datapath #(
   parameter int NUM_TILES    = 4096,
   parameter int MAX_RECORDS  = 16384,
   parameter int NUM_DATASETS = 1024,
   parameter int NUM_CHROMS   = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  tioc_pkg::cmd_type  cmd,
   output tioc_pkg::stat_type stat,
   input  logic [4:0]         req_chrom,
   input  logic [11:0]        req_tile,
   input  logic [9:0]         req_dataset,
   input  logic [31:0]        req_region_start,
   input  logic [31:0]        req_region_end,
   input  logic               csr_valid,
   input  logic [4:0]         csr_data,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [31:0]        rsp_count_value,
   output logic [1:0]         rsp_status
);

   localparam int TW    = $clog2(NUM_TILES);
   localparam int RW    = $clog2(MAX_RECORDS);
   localparam int DW    = $clog2(NUM_DATASETS);
   localparam int CHW   = (NUM_CHROMS > 1) ? $clog2(NUM_CHROMS) : 1;
   localparam int CLR_N = (NUM_TILES > NUM_DATASETS) ? NUM_TILES : NUM_DATASETS;
   localparam int CLRW  = $clog2(CLR_N);
   localparam int LW    = tioc_pkg::LOCAL_W;

   // memories
   logic [RW:0]   cnt_mem   [NUM_TILES];
   logic [RW-1:0] first_mem [NUM_TILES];
   logic [DW-1:0] rds_mem   [MAX_RECORDS];
   logic [31:0]   rst_mem   [MAX_RECORDS];
   logic [31:0]   ren_mem   [MAX_RECORDS];
   logic [31:0]   ctr_mem   [NUM_DATASETS];

   // registers
   logic [4:0]    tile_bits_ff, tile_bits_in;
   logic [4:0]    chrom_ff;
   logic [11:0]   tile_ff;
   logic [9:0]    dataset_ff;
   logic [31:0]   q1_ff, q2_ff;
   logic [11:0]   base_ff [NUM_CHROMS];
   logic [11:0]   base_in [NUM_CHROMS];
   logic [RW:0]   filled_ff, filled_in;
   logic [11:0]   last_tile_ff, last_tile_in;
   logic          any_ff, any_in;
   logic [TW-1:0] cur_tile_ff, cur_tile_in;
   logic [LW-1:0] cur_local_ff, cur_local_in;
   logic [LW-1:0] remain_ff, remain_in;
   logic [31:0]   hits_ff, hits_in;
   logic [RW:0]   rec_n_ff, rec_n_in;
   logic [RW-1:0] rec_base_ff, rec_base_in;
   logic [RW:0]   rec_j_ff, rec_j_in;
   logic [31:0]   res_count_ff, res_count_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_count_ff, rsp_count_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [CLRW-1:0] clr_idx_ff, clr_idx_in;

   // registered read data
   logic [RW:0]   cnt_rd_ff;
   logic [RW-1:0] first_rd_ff;
   logic [DW-1:0] rd_ff;
   logic [31:0]   rs_ff, re_ff;
   logic [31:0]   ctr_rd_ff;

   // address and field helpers
   logic [31:0]   tile_ext, dataset_ext, chrom_ext, clr_ext;
   logic [TW-1:0] tile_idx;
   logic [DW-1:0] dataset_idx;
   logic [CHW-1:0] chrom_idx;
   logic [4:0]    tb;
   logic [LW-1:0] n1, n2;
   logic [31:0]   first, span, base_sel, rec_r, e_shift;
   logic          chrom_ok, ds_ok, drop;
   logic [TW-1:0] cr_addr;
   logic [DW-1:0] ctr_raddr;

   assign tile_ext    = {20'd0, tile_ff};
   assign dataset_ext = {22'd0, dataset_ff};
   assign chrom_ext   = {27'd0, chrom_ff};
   assign clr_ext     = 32'(clr_idx_ff);
   assign tile_idx    = tile_ext[TW-1:0];
   assign dataset_idx = dataset_ext[DW-1:0];
   assign chrom_idx   = chrom_ext[CHW-1:0];
   assign chrom_ok    = chrom_ext < 32'(NUM_CHROMS);
   assign ds_ok       = dataset_ext < 32'(NUM_DATASETS);

   // query span from tile size and chromosome base
   assign tb = (tile_bits_ff < tioc_pkg::TB_MIN) ? tioc_pkg::TB_MIN :
               (tile_bits_ff > tioc_pkg::TB_MAX) ? tioc_pkg::TB_MAX : tile_bits_ff;
   always_comb begin
      logic [31:0] sh1, sh2;
      sh1 = q1_ff >> tb;
      sh2 = q2_ff >> tb;
      n1  = sh1[LW-1:0];
      n2  = (q2_ff >= q1_ff) ? (sh2[LW-1:0] - n1) : '0;
   end
   assign base_sel = chrom_ok ? {20'd0, base_ff[chrom_idx]} : 32'd0;
   assign first    = 32'(n1) + base_sel;
   assign span     = first + 32'(n2);

   // record scan tests
   assign rec_r   = 32'(rec_base_ff) + 32'(rec_j_ff);
   assign e_shift = re_ff >> tb;

   // record append check
   assign drop = (32'(filled_ff) >= 32'(MAX_RECORDS)) || (tile_ext >= 32'(NUM_TILES)) ||
                 !ds_ok || (any_ff && (tile_ff < last_tile_ff));

   // status to the controller
   assign stat.clear_done = (clr_ext == 32'(CLR_N - 1));
   assign stat.q_bad      = !chrom_ok || (span >= 32'(NUM_TILES));
   assign stat.rec_more   = (rec_j_ff < rec_n_ff) && (rec_r < 32'(MAX_RECORDS));
   assign stat.rec_hit    = !((q1_ff > re_ff) || (q2_ff < rs_ff)) &&
                            !((remain_ff != '0) && (e_shift > 32'(cur_local_ff)));
   assign stat.last_tile  = (remain_ff == '0);
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_count_value = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   // next state of datapath registers
   always_comb begin
      tile_bits_in  = tile_bits_ff;
      base_in       = base_ff;
      filled_in     = filled_ff;
      last_tile_in  = last_tile_ff;
      any_in        = any_ff;
      cur_tile_in   = cur_tile_ff;
      cur_local_in  = cur_local_ff;
      remain_in     = remain_ff;
      hits_in       = hits_ff;
      rec_n_in      = rec_n_ff;
      rec_base_in   = rec_base_ff;
      rec_j_in      = rec_j_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      clr_idx_in    = clr_idx_ff;
      if (csr_valid) tile_bits_in = csr_data;
      case (cmd.op)
         tioc_pkg::OP_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
         end
         tioc_pkg::OP_BASE: begin
            if (chrom_ok) base_in[chrom_idx] = tile_ff;
            res_count_in  = 32'd0;
            res_status_in = tioc_pkg::STATUS_OK;
         end
         tioc_pkg::OP_LD_WR: begin
            res_count_in  = 32'd0;
            res_status_in = drop ? tioc_pkg::STATUS_DROPPED : tioc_pkg::STATUS_OK;
            if (!drop) begin
               filled_in    = filled_ff + 1'b1;
               last_tile_in = tile_ff;
               any_in       = 1'b1;
            end
         end
         tioc_pkg::OP_Q_SETUP: begin
            cur_tile_in   = first[TW-1:0];
            cur_local_in  = n1;
            remain_in     = n2;
            hits_in       = 32'd0;
            res_count_in  = 32'd0;
            res_status_in = tioc_pkg::STATUS_BEYOND;
         end
         tioc_pkg::OP_TILE_GO: begin
            rec_n_in    = cnt_rd_ff;
            rec_base_in = first_rd_ff;
            rec_j_in    = '0;
         end
         tioc_pkg::OP_REC_RD: begin
            rec_j_in = rec_j_ff + 1'b1;
         end
         tioc_pkg::OP_NEXT_TILE: begin
            cur_tile_in  = cur_tile_ff + 1'b1;
            cur_local_in = cur_local_ff + 1'b1;
            remain_in    = remain_ff - 1'b1;
         end
         tioc_pkg::OP_FINISH: begin
            res_count_in  = hits_ff;
            res_status_in = tioc_pkg::STATUS_OK;
         end
         tioc_pkg::OP_HIT: begin
            hits_in = tioc_pkg::sat_inc(hits_ff);
         end
         tioc_pkg::OP_RD_OUT: begin
            res_count_in  = ds_ok ? ctr_rd_ff : 32'd0;
            res_status_in = tioc_pkg::STATUS_OK;
         end
         tioc_pkg::OP_PUSH: begin
            rsp_valid_in  = 1'b1;
            rsp_count_in  = res_count_ff;
            rsp_status_in = res_status_ff;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tile_bits_ff <= tioc_pkg::TB_RESET;
         for (int i = 0; i < NUM_CHROMS; i++) base_ff[i] <= 12'd0;
         filled_ff    <= '0;
         last_tile_ff <= 12'd0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clr_idx_ff   <= '0;
      end else begin
         tile_bits_ff <= tile_bits_in;
         base_ff      <= base_in;
         filled_ff    <= filled_in;
         last_tile_ff <= last_tile_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_idx_ff   <= clr_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.op == tioc_pkg::OP_CAPTURE) begin
         chrom_ff   <= req_chrom;
         tile_ff    <= req_tile;
         dataset_ff <= req_dataset;
         q1_ff      <= req_region_start;
         q2_ff      <= req_region_end;
      end
      cur_tile_ff   <= cur_tile_in;
      cur_local_ff  <= cur_local_in;
      remain_ff     <= remain_in;
      hits_ff       <= hits_in;
      rec_n_ff      <= rec_n_in;
      rec_base_ff   <= rec_base_in;
      rec_j_ff      <= rec_j_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   // tile tables: count cleared by the sweep, first record written with the first append
   assign cr_addr = (cmd.op == tioc_pkg::OP_TILE_RD) ? cur_tile_ff : tile_idx;
   always_ff @(posedge clock) begin
      if (cmd.op == tioc_pkg::OP_CLEAR && clr_ext < 32'(NUM_TILES)) begin
         cnt_mem[clr_ext[TW-1:0]] <= '0;
      end else if (cmd.op == tioc_pkg::OP_LD_WR && !drop) begin
         cnt_mem[tile_idx] <= cnt_rd_ff + 1'b1;
      end
      if (cmd.op == tioc_pkg::OP_LD_WR && !drop && cnt_rd_ff == '0) begin
         first_mem[tile_idx] <= filled_ff[RW-1:0];
      end
      cnt_rd_ff   <= cnt_mem[cr_addr];
      first_rd_ff <= first_mem[cr_addr];
   end

   // record stores
   always_ff @(posedge clock) begin
      if (cmd.op == tioc_pkg::OP_LD_WR && !drop) begin
         rds_mem[filled_ff[RW-1:0]] <= dataset_idx;
         rst_mem[filled_ff[RW-1:0]] <= q1_ff;
         ren_mem[filled_ff[RW-1:0]] <= q2_ff;
      end
      if (cmd.op == tioc_pkg::OP_REC_RD) begin
         rd_ff <= rds_mem[rec_r[RW-1:0]];
         rs_ff <= rst_mem[rec_r[RW-1:0]];
         re_ff <= ren_mem[rec_r[RW-1:0]];
      end
   end

   // dataset hit counters, read-modify-write: read under OP_HIT, written back under OP_CNT_WR
   assign ctr_raddr = (cmd.op == tioc_pkg::OP_HIT) ? rd_ff : dataset_idx;
   always_ff @(posedge clock) begin
      if (cmd.op == tioc_pkg::OP_CLEAR && clr_ext < 32'(NUM_DATASETS)) begin
         ctr_mem[clr_ext[DW-1:0]] <= 32'd0;
      end else if (cmd.op == tioc_pkg::OP_CNT_WR) begin
         ctr_mem[rd_ff] <= tioc_pkg::sat_inc(ctr_rd_ff);
      end
      ctr_rd_ff <= ctr_mem[ctr_raddr];
   end

endmodule

[hw/rtl/tiled_interval_overlap_counter_core.sv]
// tiled_interval_overlap_counter_core: top level of the tiled interval overlap counter
// depends on tioc_pkg, tioc_ctrl and tioc_datapath
//
// Usage: the req_ channel carries one transaction per item (kind, chrom, tile, dataset,
// region_start, region_end); an item is taken when req_valid is high and req_stall low.
// Each item gives exactly one rsp_ transaction (count_value, status), taken when
// rsp_valid is high and rsp_stall low. The csr_ channel writes tile_bits (always ready).
// Items are worked one at a time by a sequencer over single-port table memories:
//   set base and load record update the tables, read counter reads a dataset counter;
//   a query reads the count of every tile spanned, then each stored record of that tile,
//   and counts each hit (record stores and counter memory each read once a cycle).
// The block is ready for the next item as the last result enters the output register.
// After reset a clearing pass over max(NUM_TILES, NUM_DATASETS) entries zeroes the tile
// counts and dataset counters; req_stall stays high during it, csr writes are taken.
// When the receiver stalls, the result holds in the output register and the finished
// item waits before the block takes another one.
module tiled_interval_overlap_counter_core #(
   parameter int NUM_TILES    = 4096,
   parameter int MAX_RECORDS  = 16384,
   parameter int NUM_DATASETS = 1024,
   parameter int NUM_CHROMS   = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [4:0]  req_chrom,
   input  logic [11:0] req_tile,
   input  logic [9:0]  req_dataset,
   input  logic [31:0] req_region_start,
   input  logic [31:0] req_region_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_count_value,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);

   tioc_pkg::cmd_type  cmd;
   tioc_pkg::stat_type stat;

   // configuration is always accepted
   assign csr_ready = 1'b1;

   // sequencer
   tioc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // tables and arithmetic
   tioc_datapath #(
      .NUM_TILES    (NUM_TILES),
      .MAX_RECORDS  (MAX_RECORDS),
      .NUM_DATASETS (NUM_DATASETS),
      .NUM_CHROMS   (NUM_CHROMS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_chrom        (req_chrom),
      .req_tile         (req_tile),
      .req_dataset      (req_dataset),
      .req_region_start (req_region_start),
      .req_region_end   (req_region_end),
      .csr_valid        (csr_valid && csr_ready),
      .csr_data         (csr_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_count_value  (rsp_count_value),
      .rsp_status       (rsp_status)
   );

endmodule

[hw/rtl/tioc_checker.sv]
// tioc_checker: port-level assertions for the overlap counter top level
// depends on tioc_pkg; bound to tiled_interval_overlap_counter_core
module tioc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_count_value,
   input logic [1:0]  rsp_status
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_count_value) && $stable(rsp_status))
      else $error("stalled result changed");

   // dropped record reports zero count
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == tioc_pkg::STATUS_DROPPED |-> rsp_count_value == 32'd0)
      else $error("dropped record with nonzero count");

   // one item at a time: no item taken in the cycle after another
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item taken while busy");

   // no unused status code
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= tioc_pkg::STATUS_BEYOND)
      else $error("unused status code");

endmodule

bind tiled_interval_overlap_counter_core tioc_checker u_tioc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_count_value (rsp_count_value),
   .rsp_status      (rsp_status)
);
